[sv/tfn_pkg.sv]
// ============================================================================
// tfn_pkg: shared types and helpers for the triangle face normal block
// Beat structs for both channels, the fixed-width stage records of the
// back half of the pipeline, and the one-step square root and divide cells.
// ============================================================================
package tfn_pkg;

    localparam int OUT_WIDTH  = 32;
    localparam int SW         = 31;                 // scaled magnitude width
    localparam int SQ_WIDTH   = 2 * SW;
    localparam int L2_WIDTH   = 64;
    localparam int LEN_WIDTH  = 32;
    localparam int NUM_WIDTH  = 62;
    localparam int FRAC_BITS  = 30;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_BITS   = 32;
    localparam int DIV_STAGES = DIV_BITS / 2;       // two quotient bits per stage
    localparam logic [OUT_WIDTH-1:0] UNIT = OUT_WIDTH'(1) << FRAC_BITS;

    typedef struct packed {
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] c_x;
        logic signed [31:0] c_y;
        logic signed [31:0] c_z;
    } t_tri_in;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] norm_x;
        logic signed [OUT_WIDTH-1:0] norm_y;
        logic signed [OUT_WIDTH-1:0] norm_z;
        logic                        degenerate;
    } t_norm_out;

    typedef struct packed {
        logic [2:0] neg;
        logic       degen;
    } t_side;

    typedef struct packed {
        t_side                         side;
        logic [2:0][SW-1:0]            s;
        logic [2:0][SQ_WIDTH-1:0]      sq;
    } t_sq_stage;

    typedef struct packed {
        t_side                 side;
        logic [2:0][SW-1:0]    s;
        logic [L2_WIDTH-1:0]   rem;
        logic [L2_WIDTH-1:0]   res;
    } t_rt_stage;

    typedef struct packed {
        t_side                 side;
        logic [2:0][SW-1:0]    s;
        logic [LEN_WIDTH-1:0]  len;
    } t_rnd_stage;

    typedef struct packed {
        t_side                       side;
        logic [2:0][LEN_WIDTH-1:0]   r;
        logic [2:0][DIV_BITS-1:0]    q;
        logic [LEN_WIDTH-1:0]        d;
    } t_dv_stage;

    // One digit of the bit-pair square root.
    function automatic t_rt_stage sqrt_step(t_rt_stage x, logic [L2_WIDTH-1:0] bitv);
        t_rt_stage y;
        y = x;
        if (x.rem >= x.res + bitv) begin
            y.rem = x.rem - (x.res + bitv);
            y.res = (x.res >> 1) + bitv;
        end else begin
            y.res = x.res >> 1;
        end
        return y;
    endfunction

    // One restoring-division step for all three components.
    function automatic t_dv_stage div_step(t_dv_stage x);
        t_dv_stage        y;
        logic [LEN_WIDTH:0] t;
        y = x;
        for (int i = 0; i < 3; i++) begin
            t = {x.r[i], x.q[i][DIV_BITS-1]};
            if (t >= {1'b0, x.d}) begin
                y.r[i] = LEN_WIDTH'(t - {1'b0, x.d});
                y.q[i] = {x.q[i][DIV_BITS-2:0], 1'b1};
            end else begin
                y.r[i] = t[LEN_WIDTH-1:0];
                y.q[i] = {x.q[i][DIV_BITS-2:0], 1'b0};
            end
        end
        return y;
    endfunction

endpackage

[sv/triangle_face_normal_top.sv]
// ============================================================================
// triangle_face_normal_top: unit normal of a triangle
// Edges, exact cross product, normalization, square root and division in a
// fully pipelined datapath that takes one triangle per clock while busy is low.
// ============================================================================
// Usage:
//   A triangle beat (three vertices, x/y/z each) is taken on the rising edge
//   at which start is high and busy is low. busy is high during reset and in
//   the cycle after it and low from then on, so a new triangle may be offered on
//   every clock.
//   Each result beat appears on o_norm for exactly one cycle with strobe high.
//   The receiver cannot hold results off, and none is needed: results leave
//   in the order triangles entered.
//   Throughput is one triangle per cycle while busy is low.
//   The depth is set by the 32-step square root (one digit per stage) and
//   the 32-bit quotient divider (two bits per stage), with a leading-zero
//   normalizer of one shift step per stage in front of them.
//   Reset clears the valid chain, so nothing in flight at reset comes out.
//   A triangle whose cross product is zero gives degenerate high and a zero
//   normal; otherwise components are signed Q2.30, saturated at unit length.
// ============================================================================
module triangle_face_normal_top #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  tfn_pkg::t_tri_in    i_tri,
    output logic                busy,
    output logic                strobe,
    output tfn_pkg::t_norm_out  o_norm
);

    localparam int W    = COORD_WIDTH;
    localparam int DW   = W + 1;          // edge component width
    localparam int PW   = 2 * DW;         // product and cross product width
    localparam int MW   = 2 * W + 1;      // cross product magnitude width
    localparam int NSH  = $clog2(MW);     // normalizer shift steps
    localparam int NSTG = 57 + NSH;       // register stages, accept to strobe

    typedef struct packed {
        tfn_pkg::t_side      side;
        logic [2:0][MW-1:0]  m;
    } t_nrm_stage;

    logic                   r_busy;
    logic [NSTG-1:0]        r_vld;
    logic                   in_fire;

    logic signed [DW-1:0]   r_u [3];
    logic signed [DW-1:0]   r_v [3];
    logic signed [PW-1:0]   r_p [6];
    logic signed [PW-1:0]   r_c [3];
    logic [PW-1:0]          n_mag [3];
    t_nrm_stage             r_nrm [NSH+1];
    logic [tfn_pkg::SW-1:0] n_s [3];
    tfn_pkg::t_sq_stage     r_sq;
    tfn_pkg::t_rt_stage     r_rt [tfn_pkg::SQRT_STEPS+1];
    tfn_pkg::t_rnd_stage    r_rnd;
    tfn_pkg::t_dv_stage     r_dv [tfn_pkg::DIV_STAGES+1];
    logic [tfn_pkg::NUM_WIDTH-1:0] n_num [3];
    tfn_pkg::t_norm_out     n_out;
    tfn_pkg::t_norm_out     r_out;

    assign in_fire = start & ~r_busy;
    assign busy    = r_busy;
    assign strobe  = r_vld[NSTG-1];
    assign o_norm  = r_out;

    // Control: the busy flag and the valid chain that follows every beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_vld  <= '0;
        end else begin
            r_busy <= 1'b0;
            r_vld  <= {r_vld[NSTG-2:0], in_fire};
        end
    end

    // Edges u = b - a and v = c - a from the low COORD_WIDTH bits of each
    // coordinate, sign-extended by one bit so the difference cannot wrap.
    always_ff @(posedge i_clk) begin
        r_u[0] <= {i_tri.b_x[W-1], i_tri.b_x[W-1:0]} - {i_tri.a_x[W-1], i_tri.a_x[W-1:0]};
        r_u[1] <= {i_tri.b_y[W-1], i_tri.b_y[W-1:0]} - {i_tri.a_y[W-1], i_tri.a_y[W-1:0]};
        r_u[2] <= {i_tri.b_z[W-1], i_tri.b_z[W-1:0]} - {i_tri.a_z[W-1], i_tri.a_z[W-1:0]};
        r_v[0] <= {i_tri.c_x[W-1], i_tri.c_x[W-1:0]} - {i_tri.a_x[W-1], i_tri.a_x[W-1:0]};
        r_v[1] <= {i_tri.c_y[W-1], i_tri.c_y[W-1:0]} - {i_tri.a_y[W-1], i_tri.a_y[W-1:0]};
        r_v[2] <= {i_tri.c_z[W-1], i_tri.c_z[W-1:0]} - {i_tri.a_z[W-1], i_tri.a_z[W-1:0]};
    end

    // Six signed partial products, then the three exact cross product terms.
    always_ff @(posedge i_clk) begin
        r_p[0] <= r_u[1] * r_v[2];
        r_p[1] <= r_u[2] * r_v[1];
        r_p[2] <= r_u[2] * r_v[0];
        r_p[3] <= r_u[0] * r_v[2];
        r_p[4] <= r_u[0] * r_v[1];
        r_p[5] <= r_u[1] * r_v[0];
        for (int i = 0; i < 3; i++) begin
            r_c[i] <= r_p[2*i] - r_p[2*i+1];
        end
    end

    // Sign and magnitude. The degenerate flag is decided here, once.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_mag[i] = r_c[i][PW-1] ? (-r_c[i]) : r_c[i];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_nrm[0].m[i]        <= n_mag[i][MW-1:0];
            r_nrm[0].side.neg[i] <= r_c[i][PW-1];
        end
        r_nrm[0].side.degen <= (r_c[0] == '0) && (r_c[1] == '0) && (r_c[2] == '0);
    end

    // Leading-zero normalizer: every stage tries one power-of-two shift on
    // all three magnitudes together, steered by the OR of the three words,
    // so the largest one ends with its top bit at the MSB.
    for (genvar j = 0; j < NSH; j++) begin : g_nrm
        localparam int SH = 1 << (NSH - 1 - j);
        logic [MW-1:0] orw;
        assign orw = r_nrm[j].m[0] | r_nrm[j].m[1] | r_nrm[j].m[2];
        always_ff @(posedge i_clk) begin
            r_nrm[j+1].side <= r_nrm[j].side;
            for (int i = 0; i < 3; i++) begin
                if (orw[MW-1 -: SH] == '0) begin
                    r_nrm[j+1].m[i] <= r_nrm[j].m[i] << SH;
                end else begin
                    r_nrm[j+1].m[i] <= r_nrm[j].m[i];
                end
            end
        end
    end

    // The top 31 bits are the scaled magnitudes; square them, then sum.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_s[i] = r_nrm[NSH].m[i][MW-1 -: tfn_pkg::SW];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq.side <= r_nrm[NSH].side;
        for (int i = 0; i < 3; i++) begin
            r_sq.s[i]  <= n_s[i];
            r_sq.sq[i] <= {{tfn_pkg::SW{1'b0}}, n_s[i]} * {{tfn_pkg::SW{1'b0}}, n_s[i]};
        end
        r_rt[0].side <= r_sq.side;
        r_rt[0].s    <= r_sq.s;
        r_rt[0].rem  <= tfn_pkg::L2_WIDTH'(r_sq.sq[0]) + tfn_pkg::L2_WIDTH'(r_sq.sq[1])
                      + tfn_pkg::L2_WIDTH'(r_sq.sq[2]);
        r_rt[0].res  <= '0;
    end

    // Square root, one result digit per stage.
    for (genvar j = 0; j < tfn_pkg::SQRT_STEPS; j++) begin : g_sqrt
        localparam logic [tfn_pkg::L2_WIDTH-1:0] BITV =
            tfn_pkg::L2_WIDTH'(1) << (tfn_pkg::L2_WIDTH - 2 - 2 * j);
        always_ff @(posedge i_clk) begin
            r_rt[j+1] <= tfn_pkg::sqrt_step(r_rt[j], BITV);
        end
    end

    // Round the root to nearest, then form the rounded dividends.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_num[i] = {r_rnd.s[i], {tfn_pkg::FRAC_BITS{1'b0}}}
                     + tfn_pkg::NUM_WIDTH'(r_rnd.len >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rnd.side <= r_rt[tfn_pkg::SQRT_STEPS].side;
        r_rnd.s    <= r_rt[tfn_pkg::SQRT_STEPS].s;
        r_rnd.len  <= tfn_pkg::LEN_WIDTH'(r_rt[tfn_pkg::SQRT_STEPS].res
                    + ((r_rt[tfn_pkg::SQRT_STEPS].rem > r_rt[tfn_pkg::SQRT_STEPS].res)
                       ? tfn_pkg::L2_WIDTH'(1) : tfn_pkg::L2_WIDTH'(0)));
        r_dv[0].side <= r_rnd.side;
        r_dv[0].d    <= r_rnd.len;
        for (int i = 0; i < 3; i++) begin
            // The high part of the dividend is below 2^30 and so below len.
            r_dv[0].r[i] <= {2'b00, n_num[i][tfn_pkg::NUM_WIDTH-1:tfn_pkg::DIV_BITS]};
            r_dv[0].q[i] <= n_num[i][tfn_pkg::DIV_BITS-1:0];
        end
    end

    // Restoring divider, two quotient bits per stage.
    for (genvar j = 0; j < tfn_pkg::DIV_STAGES; j++) begin : g_div
        always_ff @(posedge i_clk) begin
            r_dv[j+1] <= tfn_pkg::div_step(tfn_pkg::div_step(r_dv[j]));
        end
    end

    // Saturate at unit length, restore the signs, zero degenerate triangles.
    always_comb begin
        logic [tfn_pkg::OUT_WIDTH-1:0] q [3];
        for (int i = 0; i < 3; i++) begin
            q[i] = r_dv[tfn_pkg::DIV_STAGES].q[i];
            if (q[i] > tfn_pkg::UNIT) begin
                q[i] = tfn_pkg::UNIT;
            end
            if (r_dv[tfn_pkg::DIV_STAGES].side.neg[i]) begin
                q[i] = -q[i];
            end
            if (r_dv[tfn_pkg::DIV_STAGES].side.degen) begin
                q[i] = '0;
            end
        end
        n_out.norm_x     = q[0];
        n_out.norm_y     = q[1];
        n_out.norm_z     = q[2];
        n_out.degenerate = r_dv[tfn_pkg::DIV_STAGES].side.degen;
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // Every accepted triangle comes out after the fixed latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(NSTG) strobe)
        else $error("accepted triangle did not produce a result on time");

    // A result with no preceding accept is invented.
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        strobe |-> $past(r_vld[NSTG-2]))
        else $error("result strobe without an item in flight");

    // A degenerate result carries a zero normal.
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (strobe && o_norm.degenerate) |->
            (o_norm.norm_x == '0 && o_norm.norm_y == '0 && o_norm.norm_z == '0))
        else $error("degenerate result with nonzero normal");

    // Components never exceed unit length.
    a_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        strobe |->
            (o_norm.norm_x <= $signed(tfn_pkg::UNIT) && o_norm.norm_x >= -$signed(tfn_pkg::UNIT)
          && o_norm.norm_y <= $signed(tfn_pkg::UNIT) && o_norm.norm_y >= -$signed(tfn_pkg::UNIT)
          && o_norm.norm_z <= $signed(tfn_pkg::UNIT) && o_norm.norm_z >= -$signed(tfn_pkg::UNIT)))
        else $error("normal component beyond unit length");

endmodule
